// File: rtl/core/cep_pkg.sv
// Shared types and constants for the cursor editor with prefix maximum.
// Used by the controller, the datapath, the top level and the checker.
`default_nettype none
package cep_pkg;

   localparam int CAPACITY = 1024;

   localparam int KIND_W  = 3;
   localparam int VALUE_W = 32;
   localparam int POS_W   = 11;
   localparam int SUM_W   = 48;

   localparam logic [KIND_W-1:0] OP_INSERT     = 3'd0;
   localparam logic [KIND_W-1:0] OP_DELETE     = 3'd1;
   localparam logic [KIND_W-1:0] OP_MOVE_LEFT  = 3'd2;
   localparam logic [KIND_W-1:0] OP_MOVE_RIGHT = 3'd3;
   localparam logic [KIND_W-1:0] OP_QUERY      = 3'd4;

   localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

   typedef struct packed {
      logic [KIND_W-1:0]         kind;
      logic signed [VALUE_W-1:0] value;
      logic [POS_W-1:0]          position;
   } cep_req_type;

   typedef struct packed {
      logic signed [SUM_W-1:0] max_prefix;
      logic                    in_range;
   } cep_rsp_type;

   typedef enum logic [2:0] {
      ACT_NONE,
      ACT_PUSH_NEW,
      ACT_DELETE,
      ACT_MOVE_LEFT,
      ACT_PUSH_RIGHT,
      ACT_QUERY
   } cep_act_type;

   typedef struct packed {
      logic        load;
      logic        commit;
      cep_act_type act;
   } cep_cmd_type;

   typedef struct packed {
      logic full;
      logic left_empty;
      logic right_empty;
      logic left_max;
   } cep_status_type;

endpackage
`default_nettype wire

// File: rtl/core/cursor_editor_prefix_max.sv
// Latency: a query result shows on rsp_word the cycle after start is taken.
// A new word is taken only while busy is low; busy is high for the cycle after
// each accept, while the registered memory read is written back.
// Reset clears the stack counts and controller; memories are not cleared.
// The receiver cannot stall: rsp_valid lasts exactly one cycle.
`default_nettype none
module cursor_editor_prefix_max #(
   parameter int CAPACITY = cep_pkg::CAPACITY
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire cep_pkg::cep_req_type req_word,
   output logic                      busy,
   output logic                      rsp_valid,
   output cep_pkg::cep_rsp_type      rsp_word
);

   cep_pkg::cep_cmd_type    cmd;
   cep_pkg::cep_status_type status;

   cep_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req       (req_word),
      .status    (status),
      .busy      (busy),
      .cmd       (cmd),
      .rsp_valid (rsp_valid)
   );

   cep_dp #(
      .CAPACITY (CAPACITY)
   ) u_dp (
      .clock  (clock),
      .reset  (reset),
      .req    (req_word),
      .cmd    (cmd),
      .status (status),
      .rsp    (rsp_word)
   );

endmodule
`default_nettype wire

// File: rtl/core/cep_ctrl.sv
// Controller: accepts a word, resolves it to an action and sequences the
// read and write cycles. Depends on cep_pkg.
`default_nettype none
module cep_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   input  wire cep_pkg::cep_req_type    req,
   input  wire cep_pkg::cep_status_type status,
   output logic                         busy,
   output cep_pkg::cep_cmd_type         cmd,
   output logic                         rsp_valid
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EXEC = 1'b1;

   logic                 state_ff, state_in;
   cep_pkg::cep_act_type act_ff, act_in;

   always_comb begin
      act_in = cep_pkg::ACT_NONE;
      unique case (req.kind)
         cep_pkg::OP_INSERT: begin
            if (!status.full) act_in = cep_pkg::ACT_PUSH_NEW;
         end
         cep_pkg::OP_DELETE: begin
            if (!status.left_empty) act_in = cep_pkg::ACT_DELETE;
         end
         cep_pkg::OP_MOVE_LEFT: begin
            if (!status.left_empty) act_in = cep_pkg::ACT_MOVE_LEFT;
         end
         cep_pkg::OP_MOVE_RIGHT: begin
            if (!status.right_empty && !status.left_max) act_in = cep_pkg::ACT_PUSH_RIGHT;
         end
         cep_pkg::OP_QUERY: begin
            act_in = cep_pkg::ACT_QUERY;
         end
         default: begin
            act_in = cep_pkg::ACT_NONE;
         end
      endcase
   end

   always_comb begin
      state_in   = state_ff;
      cmd.load   = 1'b0;
      cmd.commit = 1'b0;
      cmd.act    = act_ff;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.act = act_in;
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.commit = 1'b1;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         act_ff   <= cep_pkg::ACT_NONE;
      end else begin
         state_ff <= state_in;
         if (cmd.load) act_ff <= act_in;
      end
   end

   assign busy      = (state_ff == ST_EXEC);
   assign rsp_valid = (state_ff == ST_EXEC) && (act_ff == cep_pkg::ACT_QUERY);

endmodule
`default_nettype wire

// File: rtl/core/cep_dp.sv
// Datapath: left/right value stacks, running sum and prefix maximum memories,
// stack counts and the result word. Depends on cep_pkg.
`default_nettype none
module cep_dp #(
   parameter int CAPACITY = cep_pkg::CAPACITY
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire cep_pkg::cep_req_type req,
   input  wire cep_pkg::cep_cmd_type cmd,
   output cep_pkg::cep_status_type   status,
   output cep_pkg::cep_rsp_type      rsp
);

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int AW = $clog2(CAPACITY);
   localparam int VW = cep_pkg::VALUE_W;
   localparam int SW = cep_pkg::SUM_W;

   logic signed [VW-1:0] lv_mem   [CAPACITY];
   logic signed [VW-1:0] rv_mem   [CAPACITY];
   logic signed [SW-1:0] sum_mem  [CAPACITY];
   logic signed [SW-1:0] best_mem [CAPACITY];

   logic [CW-1:0] lc_ff, lc_in;
   logic [CW-1:0] rc_ff, rc_in;

   logic signed [VW-1:0] val_ff;
   logic signed [VW-1:0] lv_rd_ff;
   logic signed [VW-1:0] rv_rd_ff;
   logic signed [SW-1:0] sum_rd_ff;
   logic signed [SW-1:0] best_rd_ff;
   logic                 base_ff;
   logic                 k_ok_ff;

   logic [AW-1:0]        lc_m1, rc_m1, k_m1, rd_addr;
   logic                 k_ok;
   logic signed [VW-1:0] push_val;
   logic signed [SW-1:0] sum_prev, best_prev, sum_new, best_new;
   logic                 push;

   assign lc_m1 = AW'(lc_ff - CW'(1));
   assign rc_m1 = AW'(rc_ff - CW'(1));
   assign k_m1  = AW'(32'(req.position) - 32'd1);
   assign k_ok  = 32'(req.position) <= 32'(lc_ff);

   assign status.full        = (32'(lc_ff) + 32'(rc_ff)) >= 32'(CAPACITY);
   assign status.left_empty  = (lc_ff == '0);
   assign status.right_empty = (rc_ff == '0);
   assign status.left_max    = (lc_ff == CW'(CAPACITY));

   assign rd_addr = (cmd.act == cep_pkg::ACT_QUERY) ? k_m1 : lc_m1;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         val_ff     <= req.value;
         k_ok_ff    <= k_ok;
         base_ff    <= (cmd.act == cep_pkg::ACT_QUERY) ? (req.position == '0)
                                                       : (lc_ff == '0);
         lv_rd_ff   <= lv_mem[lc_m1];
         rv_rd_ff   <= rv_mem[rc_m1];
         sum_rd_ff  <= sum_mem[rd_addr];
         best_rd_ff <= best_mem[rd_addr];
      end
   end

   assign push      = cmd.commit && ((cmd.act == cep_pkg::ACT_PUSH_NEW) ||
                                     (cmd.act == cep_pkg::ACT_PUSH_RIGHT));
   assign push_val  = (cmd.act == cep_pkg::ACT_PUSH_RIGHT) ? rv_rd_ff : val_ff;
   assign sum_prev  = base_ff ? '0 : sum_rd_ff;
   assign best_prev = base_ff ? cep_pkg::SUM_MIN : best_rd_ff;
   assign sum_new   = sum_prev + SW'(push_val);
   assign best_new  = (sum_new > best_prev) ? sum_new : best_prev;

   always_ff @(posedge clock) begin
      if (push) begin
         lv_mem[lc_ff[AW-1:0]]   <= push_val;
         sum_mem[lc_ff[AW-1:0]]  <= sum_new;
         best_mem[lc_ff[AW-1:0]] <= best_new;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit && (cmd.act == cep_pkg::ACT_MOVE_LEFT)) begin
         rv_mem[rc_ff[AW-1:0]] <= lv_rd_ff;
      end
   end

   always_comb begin
      lc_in = lc_ff;
      rc_in = rc_ff;
      if (cmd.commit) begin
         unique case (cmd.act)
            cep_pkg::ACT_PUSH_NEW: begin
               lc_in = lc_ff + CW'(1);
            end
            cep_pkg::ACT_PUSH_RIGHT: begin
               lc_in = lc_ff + CW'(1);
               rc_in = rc_ff - CW'(1);
            end
            cep_pkg::ACT_DELETE: begin
               lc_in = lc_ff - CW'(1);
            end
            cep_pkg::ACT_MOVE_LEFT: begin
               lc_in = lc_ff - CW'(1);
               rc_in = rc_ff + CW'(1);
            end
            default: begin
               lc_in = lc_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lc_ff <= '0;
         rc_ff <= '0;
      end else begin
         lc_ff <= lc_in;
         rc_ff <= rc_in;
      end
   end

   assign rsp.max_prefix = k_ok_ff ? best_prev : '0;
   assign rsp.in_range   = k_ok_ff;

endmodule
`default_nettype wire

// File: rtl/core/cep_checker.sv
// Port-level checks for cursor_editor_prefix_max, bound to the top level.
// Depends on cep_pkg.
`default_nettype none
module cep_checker (
   input wire logic                 clock,
   input wire logic                 reset,
   input wire logic                 start,
   input wire cep_pkg::cep_req_type req_word,
   input wire logic                 busy,
   input wire logic                 rsp_valid,
   input wire cep_pkg::cep_rsp_type rsp_word
);

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after accept");

   a_busy_one_cycle: assert property (@(posedge clock) disable iff (reset)
      busy |=> !busy)
      else $error("busy held longer than one cycle");

   a_rsp_follows_query: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($past(start && !busy) && $past(req_word.kind) == cep_pkg::OP_QUERY))
      else $error("result without a query accepted the cycle before");

   a_out_of_range_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_word.in_range) |-> (rsp_word.max_prefix == '0))
      else $error("out-of-range result carries nonzero value");

endmodule

bind cursor_editor_prefix_max cep_checker u_cep_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .req_word  (req_word),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_word  (rsp_word)
);
`default_nettype wire
